// ===== rtl/psl_pkg.sv =====
// ----------------------------------------------------------------------------
// psl_pkg
// token codes, character codes, keyword table and symbol search result type
// ----------------------------------------------------------------------------
package psl_pkg;

  // token kinds 0..20 are the keywords in table order
  localparam logic [5:0] K_BOOL    = 6'd21;
  localparam logic [5:0] K_ID      = 6'd22;
  localparam logic [5:0] K_INT     = 6'd23;
  localparam logic [5:0] K_REAL    = 6'd24;
  localparam logic [5:0] K_PLUS    = 6'd25;
  localparam logic [5:0] K_MINUS   = 6'd26;
  localparam logic [5:0] K_TIMES   = 6'd27;
  localparam logic [5:0] K_SLASH   = 6'd28;
  localparam logic [5:0] K_EQ      = 6'd29;
  localparam logic [5:0] K_SEMI    = 6'd30;
  localparam logic [5:0] K_COMMA   = 6'd31;
  localparam logic [5:0] K_LPAR    = 6'd32;
  localparam logic [5:0] K_RPAR    = 6'd33;
  localparam logic [5:0] K_LT      = 6'd34;
  localparam logic [5:0] K_LE      = 6'd35;
  localparam logic [5:0] K_NE      = 6'd36;
  localparam logic [5:0] K_GT      = 6'd37;
  localparam logic [5:0] K_GE      = 6'd38;
  localparam logic [5:0] K_COLON   = 6'd39;
  localparam logic [5:0] K_ASSIGN  = 6'd40;
  localparam logic [5:0] K_DOT     = 6'd41;
  localparam logic [5:0] K_DOTDOT  = 6'd42;
  localparam logic [5:0] K_INVALID = 6'd43;
  localparam logic [5:0] K_END     = 6'd44;

  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  localparam logic [30:0] VMAX = 31'h7fffffff;

  localparam int KW_NUM = 23;
  localparam int KW_BYTES = 9;

  localparam logic [71:0] KW_STR [KW_NUM] = '{
    "program", "procedure", "begin", "end", "if", "then", "else", "while", "do",
    "div", "mod", "and", "or", "not", "var", "real", "integer", "boolean",
    "const", "repeat", "until", "true", "false"
  };
  localparam logic [3:0] KW_LEN [KW_NUM] = '{
    4'd7, 4'd9, 4'd5, 4'd3, 4'd2, 4'd4, 4'd4, 4'd5, 4'd2, 4'd3, 4'd3, 4'd3,
    4'd2, 4'd3, 4'd3, 4'd4, 4'd7, 4'd7, 4'd5, 4'd6, 4'd5, 4'd4, 4'd5
  };

  typedef struct packed {
    logic       hit;
    logic [5:0] kind;
    logic       bv;
  } kw_t;

  // symbol search result, one-cycle pulse on done
  typedef struct packed {
    logic       done;
    logic       full;
    logic [6:0] sym;
  } st_res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c >= 8'h61 && c <= 8'h7a;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  // true when scanning c from idle yields a token
  function automatic logic idle_emits(input logic [7:0] c, input logic eof);
    logic quiet;
    quiet = is_space(c) || is_digit(c) || is_alpha(c) || c == CH_LPAREN ||
            c == CH_LBRACE || c == CH_LT || c == CH_GT || c == CH_COLON || c == CH_DOT;
    return eof || !quiet;
  endfunction

  // string literal is right-justified: put first char in byte 0
  function automatic logic [71:0] kw_norm(input logic [71:0] s, input logic [3:0] len);
    logic [71:0] r;
    r = '0;
    for (int j = 0; j < KW_BYTES; j++) begin
      if (j < int'(len)) begin
        r[j*8 +: 8] = s[(int'(len) - 1 - j)*8 +: 8];
      end
    end
    return r;
  endfunction

  function automatic kw_t kw_find(input logic [71:0] txt, input logic [6:0] len);
    kw_t r;
    r = '0;
    for (int i = 0; i < KW_NUM; i++) begin
      if (!r.hit && len == {3'b000, KW_LEN[i]} && txt == kw_norm(KW_STR[i], KW_LEN[i])) begin
        r.hit  = 1'b1;
        r.kind = (i < 21) ? 6'(i) : K_BOOL;
        r.bv   = (i == 21);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/psl_symtab.sv =====
// ----------------------------------------------------------------------------
// psl_symtab
// symbol table in one synchronous memory, linear search then insert
// ----------------------------------------------------------------------------
module psl_symtab #(
  parameter int NAME_LEN      = 16,
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           clear_i,
  input  logic [NAME_LEN*8-1:0]          name_i,
  input  logic [$clog2(NAME_LEN+1)-1:0]  len_i,
  output logic                           busy_o,
  output psl_pkg::st_res_t               res_o
);

  localparam int LW = $clog2(NAME_LEN + 1);
  localparam int RW = LW + NAME_LEN * 8;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_CMP} st_e;

  st_e            state_q, state_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic [CW-1:0]  count_q, count_d;
  logic [RW-1:0]  mem [TABLE_ENTRIES];
  logic [RW-1:0]  rdata_q;
  logic           rd_en, wr_en;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic [31:0]    sym_sum;
  logic [31:0]    ins_sum;

  assign rd_addr = idx_q[AW-1:0];
  assign wr_addr = count_q[AW-1:0];
  assign sym_sum = 32'(idx_q) + 32'd1;
  assign ins_sum = 32'(count_q) + 32'd1;
  assign busy_o  = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    count_d = count_q;
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    res_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (clear_i) begin
          count_d = '0;
        end else if (start_i) begin
          idx_d   = '0;
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        if (idx_q < count_q) begin
          rd_en   = 1'b1;
          state_d = ST_CMP;
        end else begin
          // not found: insert if room
          res_o.done = 1'b1;
          state_d    = ST_IDLE;
          if (32'(count_q) < TABLE_ENTRIES) begin
            wr_en     = 1'b1;
            count_d   = count_q + CW'(1);
            res_o.sym = ins_sum[6:0];
          end else begin
            res_o.full = 1'b1;
          end
        end
      end
      ST_CMP: begin
        if (rdata_q == {len_i, name_i}) begin
          res_o.done = 1'b1;
          res_o.sym  = sym_sum[6:0];
          state_d    = ST_IDLE;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = ST_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= {len_i, name_i};
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/pascal_subset_lexer_top.sv =====
// ----------------------------------------------------------------------------
// pascal_subset_lexer_top
// character-serial lexer for a small pascal subset with a symbol table
// ----------------------------------------------------------------------------
// tokens: the accepted character is registered, scanned and the token put in the output register;
//   a pushed-back character gets a second pass, and scanning waits while the output stalls
// identifiers: the table is searched entry by entry (read then compare), a new name is
//   inserted if there is room, and the id token is registered when the search is done
// input: a new character is taken only once the previous one is fully scanned
// reset: asynchronous, scanner idle, symbol table empty (count cleared)
module pascal_subset_lexer_top #(
  parameter int NAME_LEN      = 16,
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  kind_o,
  output logic [30:0] number_value_o,
  output logic [4:0]  fraction_digits_o,
  output logic [6:0]  symbol_number_o,
  output logic        bool_value_o,
  output logic        table_full_o,
  output logic        name_truncated_o,
  output logic        number_saturated_o,
  output logic        last_o
);

  localparam int LW = $clog2(NAME_LEN + 1);
  localparam int IW = $clog2(NAME_LEN);

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_STAR, M_PAREN, M_LT, M_GT, M_COLON, M_DOT,
    M_INT, M_FRAC, M_SKIP, M_WORD, M_IDENT
  } mode_e;

  typedef enum logic [1:0] {T_IDLE, T_PROC, T_SRCH} seq_e;

  // sequencer and scan state
  seq_e                  seq_q, seq_d;
  mode_e                 mode_q, mode_d, n_mode;
  logic                  pass_q, pass_d;
  logic [7:0]            char_q, char_d;
  logic                  eof_q, eof_d;
  logic [NAME_LEN*8-1:0] buf_q, buf_d, n_buf;
  logic [LW-1:0]         len_q, len_d, n_len;
  logic [30:0]           acc_q, acc_d, n_acc;
  logic [4:0]            frac_q, frac_d, n_frac;
  logic                  trunc_q, trunc_d, n_trunc;
  logic                  sat_q, sat_d, n_sat;

  // output register
  logic        ov_q, ov_d;
  logic [5:0]  okind_q, okind_d;
  logic [30:0] oval_q, oval_d;
  logic [4:0]  ofrac_q, ofrac_d;
  logic [6:0]  osym_q, osym_d;
  logic        obool_q, obool_d, ofull_q, ofull_d, otr_q, otr_d;
  logic        osat_q, osat_d, olast_q, olast_d;

  // scan results for the current pass
  logic        emit, rescan, word, plain, end_tok;
  logic [5:0]  t_kind;
  logic [30:0] t_val;
  logic [4:0]  t_frac;
  logic        t_sat;
  logic        out_free, step_last;
  logic [3:0]  dig;
  logic [34:0] mul10;
  logic        mul_ovf;
  logic [71:0] kw_txt;
  psl_pkg::kw_t    kw;
  logic            st_start, st_clear, st_busy;
  psl_pkg::st_res_t st_res;

  // first keyword-length bytes of the name buffer
  for (genvar j = 0; j < psl_pkg::KW_BYTES; j++) begin : g_kw
    if (j < NAME_LEN) begin : g_b
      assign kw_txt[j*8 +: 8] = buf_q[j*8 +: 8];
    end else begin : g_z
      assign kw_txt[j*8 +: 8] = 8'h00;
    end
  end

  assign kw       = psl_pkg::kw_find(kw_txt, 7'(len_q));
  assign out_free = !ov_q || !out_stall_i;
  assign dig      = 4'(char_q - psl_pkg::CH_ZERO);
  // acc * 10 + digit, checked against the 31-bit ceiling
  assign mul10    = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {31'd0, dig};
  assign mul_ovf  = mul10 > {4'd0, psl_pkg::VMAX};
  // a pushed-back char scanned from idle adds a second token
  assign step_last = !(rescan && !pass_q && psl_pkg::idle_emits(char_q, eof_q));

  // one scanning pass over the held character
  always_comb begin
    n_mode  = M_IDLE;
    n_buf   = buf_q;
    n_len   = len_q;
    n_acc   = acc_q;
    n_frac  = frac_q;
    n_trunc = trunc_q;
    n_sat   = sat_q;
    emit    = 1'b0;
    rescan  = 1'b0;
    word    = 1'b0;
    plain   = 1'b0;
    end_tok = 1'b0;
    t_kind  = psl_pkg::K_INVALID;
    t_val   = '0;
    t_frac  = '0;
    t_sat   = 1'b0;
    case (mode_q)
      M_COMMENT, M_STAR: begin
        if (eof_q) begin
          emit = 1'b1; end_tok = 1'b1; t_kind = psl_pkg::K_END;
        end else if (char_q == psl_pkg::CH_RBRACE ||
                     (mode_q == M_STAR && char_q == psl_pkg::CH_RPAREN)) begin
          n_mode = M_IDLE;
        end else begin
          n_mode = (char_q == psl_pkg::CH_STAR) ? M_STAR : M_COMMENT;
        end
      end
      M_PAREN: begin
        if (!eof_q && char_q == psl_pkg::CH_STAR) begin
          n_mode = M_COMMENT;
        end else begin
          emit = 1'b1; rescan = 1'b1; t_kind = psl_pkg::K_LPAR;
        end
      end
      M_LT: begin
        emit = 1'b1;
        if (!eof_q && char_q == psl_pkg::CH_EQ) begin
          t_kind = psl_pkg::K_LE;
        end else if (!eof_q && char_q == psl_pkg::CH_GT) begin
          t_kind = psl_pkg::K_NE;
        end else begin
          t_kind = psl_pkg::K_LT; rescan = 1'b1;
        end
      end
      M_GT: begin
        emit = 1'b1;
        if (!eof_q && char_q == psl_pkg::CH_EQ) begin
          t_kind = psl_pkg::K_GE;
        end else begin
          t_kind = psl_pkg::K_GT; rescan = 1'b1;
        end
      end
      M_COLON: begin
        emit = 1'b1;
        if (!eof_q && char_q == psl_pkg::CH_EQ) begin
          t_kind = psl_pkg::K_ASSIGN;
        end else begin
          t_kind = psl_pkg::K_COLON; rescan = 1'b1;
        end
      end
      M_DOT: begin
        emit = 1'b1;
        if (!eof_q && char_q == psl_pkg::CH_DOT) begin
          t_kind = psl_pkg::K_DOTDOT;
        end else begin
          t_kind = psl_pkg::K_DOT; rescan = 1'b1;
        end
      end
      M_INT: begin
        if (!eof_q && psl_pkg::is_digit(char_q)) begin
          n_mode = M_INT;
          if (mul_ovf) begin
            n_acc = psl_pkg::VMAX; n_sat = 1'b1;
          end else begin
            n_acc = mul10[30:0];
          end
        end else if (!eof_q && psl_pkg::is_alpha(char_q)) begin
          n_mode = M_SKIP;
        end else if (!eof_q && char_q == psl_pkg::CH_DOT) begin
          n_mode = M_FRAC;
        end else if (eof_q || psl_pkg::is_space(char_q) || psl_pkg::is_punct(char_q)) begin
          emit = 1'b1; rescan = 1'b1; t_kind = psl_pkg::K_INT;
          t_val = acc_q; t_sat = sat_q;
        end else begin
          // odd byte right after a number is swallowed
          emit = 1'b1; t_kind = psl_pkg::K_INVALID;
        end
      end
      M_FRAC: begin
        if (!eof_q && psl_pkg::is_digit(char_q)) begin
          n_mode = M_FRAC;
          if (frac_q == 5'd31 || mul_ovf) begin
            n_sat = 1'b1;
          end else begin
            n_acc  = mul10[30:0];
            n_frac = frac_q + 5'd1;
          end
        end else if (!eof_q && psl_pkg::is_alpha(char_q)) begin
          n_mode = M_SKIP;
        end else begin
          emit = 1'b1; rescan = 1'b1; t_kind = psl_pkg::K_REAL;
          t_val = acc_q; t_frac = frac_q; t_sat = sat_q;
        end
      end
      M_SKIP: begin
        if (!eof_q && (psl_pkg::is_alpha(char_q) || psl_pkg::is_digit(char_q))) begin
          n_mode = M_SKIP;
        end else begin
          emit = 1'b1; rescan = 1'b1; t_kind = psl_pkg::K_INVALID;
        end
      end
      M_WORD, M_IDENT: begin
        if (!eof_q && (psl_pkg::is_alpha(char_q) ||
            psl_pkg::is_digit(char_q) || char_q == psl_pkg::CH_UNDER)) begin
          n_mode = (mode_q == M_WORD && psl_pkg::is_alpha(char_q)) ? M_WORD : M_IDENT;
          if (32'(len_q) < NAME_LEN) begin
            n_buf[len_q[IW-1:0]*8 +: 8] = char_q;
            n_len = len_q + LW'(1);
          end else begin
            n_trunc = 1'b1;
          end
        end else begin
          word = 1'b1; rescan = 1'b1; plain = (mode_q == M_WORD);
        end
      end
      default: begin
        // idle between tokens
        if (eof_q) begin
          emit = 1'b1; end_tok = 1'b1; t_kind = psl_pkg::K_END;
        end else if (psl_pkg::is_space(char_q)) begin
          n_mode = M_IDLE;
        end else if (psl_pkg::is_digit(char_q)) begin
          n_mode = M_INT; n_acc = {27'd0, dig}; n_frac = '0; n_sat = 1'b0;
        end else if (psl_pkg::is_alpha(char_q)) begin
          n_mode  = M_WORD;
          n_buf   = '0;
          n_buf[7:0] = char_q;
          n_len   = LW'(1);
          n_trunc = 1'b0;
        end else begin
          case (char_q)
            psl_pkg::CH_PLUS:   begin emit = 1'b1; t_kind = psl_pkg::K_PLUS; end
            psl_pkg::CH_MINUS:  begin emit = 1'b1; t_kind = psl_pkg::K_MINUS; end
            psl_pkg::CH_STAR:   begin emit = 1'b1; t_kind = psl_pkg::K_TIMES; end
            psl_pkg::CH_SLASH:  begin emit = 1'b1; t_kind = psl_pkg::K_SLASH; end
            psl_pkg::CH_EQ:     begin emit = 1'b1; t_kind = psl_pkg::K_EQ; end
            psl_pkg::CH_SEMI:   begin emit = 1'b1; t_kind = psl_pkg::K_SEMI; end
            psl_pkg::CH_COMMA:  begin emit = 1'b1; t_kind = psl_pkg::K_COMMA; end
            psl_pkg::CH_RPAREN: begin emit = 1'b1; t_kind = psl_pkg::K_RPAR; end
            psl_pkg::CH_LPAREN: n_mode = M_PAREN;
            psl_pkg::CH_LBRACE: n_mode = M_COMMENT;
            psl_pkg::CH_LT:     n_mode = M_LT;
            psl_pkg::CH_GT:     n_mode = M_GT;
            psl_pkg::CH_COLON:  n_mode = M_COLON;
            psl_pkg::CH_DOT:    n_mode = M_DOT;
            default:            begin emit = 1'b1; t_kind = psl_pkg::K_INVALID; end
          endcase
        end
      end
    endcase
  end

  // sequencer: accept, scan passes, symbol search, output register
  always_comb begin
    seq_d    = seq_q;
    pass_d   = pass_q;
    char_d   = char_q;
    eof_d    = eof_q;
    mode_d   = mode_q;
    buf_d    = buf_q;
    len_d    = len_q;
    acc_d    = acc_q;
    frac_d   = frac_q;
    trunc_d  = trunc_q;
    sat_d    = sat_q;
    st_start = 1'b0;
    st_clear = 1'b0;
    ov_d     = ov_q && out_stall_i;
    okind_d  = okind_q;
    oval_d   = oval_q;
    ofrac_d  = ofrac_q;
    osym_d   = osym_q;
    obool_d  = obool_q;
    ofull_d  = ofull_q;
    otr_d    = otr_q;
    osat_d   = osat_q;
    olast_d  = olast_q;
    case (seq_q)
      T_IDLE: begin
        if (in_valid_i) begin
          // fold upper case on the way in
          char_d = (char_code_i >= 8'h41 && char_code_i <= 8'h5a) ?
                   char_code_i + 8'h20 : char_code_i;
          eof_d  = end_of_input_i;
          pass_d = 1'b0;
          seq_d  = T_PROC;
        end
      end
      T_PROC: begin
        if (out_free) begin
          mode_d  = n_mode;
          buf_d   = n_buf;
          len_d   = n_len;
          acc_d   = n_acc;
          frac_d  = n_frac;
          trunc_d = n_trunc;
          sat_d   = n_sat;
          st_clear = end_tok;
          if (word && plain && !trunc_q && kw.hit) begin
            ov_d = 1'b1; okind_d = kw.kind; oval_d = '0; ofrac_d = '0; osym_d = '0;
            obool_d = kw.bv; ofull_d = 1'b0; otr_d = 1'b0; osat_d = 1'b0;
            olast_d = step_last;
          end else if (word) begin
            st_start = 1'b1;
            olast_d  = step_last;
          end else if (emit) begin
            ov_d = 1'b1; okind_d = t_kind; oval_d = t_val; ofrac_d = t_frac; osym_d = '0;
            obool_d = 1'b0; ofull_d = 1'b0; otr_d = 1'b0; osat_d = t_sat;
            olast_d = step_last;
          end
          if (word && !(plain && !trunc_q && kw.hit)) begin
            seq_d = T_SRCH;
          end else if (rescan && !pass_q) begin
            pass_d = 1'b1;
          end else begin
            seq_d = T_IDLE;
          end
        end
      end
      T_SRCH: begin
        if (st_res.done) begin
          ov_d = 1'b1; okind_d = psl_pkg::K_ID; oval_d = '0; ofrac_d = '0;
          osym_d = st_res.sym; obool_d = 1'b0; ofull_d = st_res.full;
          otr_d = trunc_q; osat_d = 1'b0;
          // pushed-back char always follows a finished word
          pass_d = 1'b1;
          seq_d  = T_PROC;
        end
      end
      default: seq_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= T_IDLE;
      mode_q  <= M_IDLE;
      pass_q  <= 1'b0;
      char_q  <= '0;
      eof_q   <= 1'b0;
      len_q   <= '0;
      acc_q   <= '0;
      frac_q  <= '0;
      trunc_q <= 1'b0;
      sat_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      seq_q   <= seq_d;
      mode_q  <= mode_d;
      pass_q  <= pass_d;
      char_q  <= char_d;
      eof_q   <= eof_d;
      len_q   <= len_d;
      acc_q   <= acc_d;
      frac_q  <= frac_d;
      trunc_q <= trunc_d;
      sat_q   <= sat_d;
      ov_q    <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    buf_q   <= buf_d;
    okind_q <= okind_d;
    oval_q  <= oval_d;
    ofrac_q <= ofrac_d;
    osym_q  <= osym_d;
    obool_q <= obool_d;
    ofull_q <= ofull_d;
    otr_q   <= otr_d;
    osat_q  <= osat_d;
    olast_q <= olast_d;
  end

  psl_symtab #(
    .NAME_LEN      (NAME_LEN),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_symtab (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (st_start),
    .clear_i (st_clear),
    .name_i  (buf_q),
    .len_i   (len_q),
    .busy_o  (st_busy),
    .res_o   (st_res)
  );

  assign in_stall_o         = (seq_q != T_IDLE);
  assign out_valid_o        = ov_q;
  assign kind_o             = okind_q;
  assign number_value_o     = oval_q;
  assign fraction_digits_o  = ofrac_q;
  assign symbol_number_o    = osym_q;
  assign bool_value_o       = obool_q;
  assign table_full_o       = ofull_q;
  assign name_truncated_o   = otr_q;
  assign number_saturated_o = osat_q;
  assign last_o             = olast_q;

  // search results only arrive while the sequencer waits for them
  a_done_in_srch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_res.done |-> seq_q == T_SRCH)
    else $error("symbol search finished outside search wait");

  // no transaction is taken while the table is busy
  a_idle_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q == T_IDLE |-> !st_busy)
    else $error("symbol table busy while lexer idle");

  // the end token closes its step
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == psl_pkg::K_END |-> last_o)
    else $error("end token not marked last");

endmodule

// ===== tb/pascal_subset_lexer_top_tb.sv =====
// ----------------------------------------------------------------------------
// pascal_subset_lexer_top_tb
// self-checking bench for the character-serial pascal subset lexer
// ----------------------------------------------------------------------------
// source text is built from keywords, identifiers, numbers, operators,
// comments, stray bytes and end marks, then fed one character per
// transaction. a predictor in the bench scans the same characters and
// queues the tokens they should produce. the monitor compares every token
// field by field with the oldest queued one. both handshakes idle and
// stall at random.
// ----------------------------------------------------------------------------
module pascal_subset_lexer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NAME_LEN      = 16;
  localparam int TABLE_ENTRIES = 64;
  localparam int N_ITEMS       = 1850;
  localparam int IDLE_LIMIT    = 4000;

  typedef struct {
    logic [7:0] ch;
    logic       eof;
  } char_item_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [30:0] value;
    logic [4:0]  frac;
    logic [6:0]  sym;
    logic        bv;
    logic        full;
    logic        trunc;
    logic        sat;
    logic        last;
  } token_t;

  // scanner modes of the predictor
  typedef enum logic [3:0] {
    S_IDLE, S_COMMENT, S_STAR, S_PAREN, S_LT, S_GT, S_COLON, S_DOT,
    S_INT, S_FRAC, S_SKIP, S_WORD, S_IDENT
  } scan_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_code = '0;
  logic        end_mark = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  kind;
  logic [30:0] number_value;
  logic [4:0]  fraction_digits;
  logic [6:0]  symbol_number;
  logic        bool_value;
  logic        table_full;
  logic        name_truncated;
  logic        number_saturated;
  logic        last;

  pascal_subset_lexer_top #(
    .NAME_LEN     (NAME_LEN),
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .char_code_i       (char_code),
    .end_of_input_i    (end_mark),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .kind_o            (kind),
    .number_value_o    (number_value),
    .fraction_digits_o (fraction_digits),
    .symbol_number_o   (symbol_number),
    .bool_value_o      (bool_value),
    .table_full_o      (table_full),
    .name_truncated_o  (name_truncated),
    .number_saturated_o(number_saturated),
    .last_o            (last)
  );

  always #6 clk = ~clk;

  // words that the lexer must recognize, in token-code order; the last
  // two are the boolean constants
  string keywords [23] = '{
    "program", "procedure", "begin", "end", "if", "then", "else", "while", "do",
    "div", "mod", "and", "or", "not", "var", "real", "integer", "boolean",
    "const", "repeat", "until", "true", "false"
  };
  string operators [20] = '{
    "+", "-", "*", "/", "=", ";", ",", "(", ")", "<", "<=", "<>", ">", ">=",
    ":", ":=", ".", "..", "}", "_"
  };

  char_item_t pending_chars[$];
  token_t     expected_tokens[$];
  int         mismatches = 0;

  // ---------------------------------------------------------------------------
  // token predictor: mirrors the scanner state and the symbol table
  // ---------------------------------------------------------------------------
  scan_e       mode = S_IDLE;
  string       name_buf;
  int unsigned acc;
  int unsigned frac_cnt;
  string       sym_names [TABLE_ENTRIES];
  int unsigned sym_count = 0;
  bit          trunc_flag;
  bit          sat_flag;
  token_t      step_tokens[$];

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_let(logic [7:0] c);
    return c >= "a" && c <= "z";
  endfunction

  function automatic bit is_ws(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_mark(logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  function automatic void put_token(logic [5:0] k, int unsigned v = 0, int unsigned f = 0,
                                    int unsigned s = 0, bit b = 0, bit fl = 0,
                                    bit tr = 0, bit sa = 0);
    token_t t;
    if (step_tokens.size() >= 2) return;
    t.kind = k; t.value = v[30:0]; t.frac = f[4:0]; t.sym = s[6:0];
    t.bv = b; t.full = fl; t.trunc = tr; t.sat = sa; t.last = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void add_letter(logic [7:0] c);
    if (name_buf.len() < NAME_LEN) name_buf = {name_buf, string'(c)};
    else trunc_flag = 1'b1;
  endfunction

  function automatic void end_token();
    put_token(psl_pkg::K_END);
    sym_count = 0;
    mode = S_IDLE;
  endfunction

  // keyword lookup for plain words, else symbol table search and insert
  function automatic void word_token(bit plain);
    if (plain && !trunc_flag) begin
      for (int i = 0; i < 23; i++) begin
        if (keywords[i] == name_buf) begin
          put_token((i < 21) ? 6'(i) : psl_pkg::K_BOOL, 0, 0, 0, i == 21);
          return;
        end
      end
    end
    for (int i = 0; i < sym_count; i++) begin
      if (sym_names[i] == name_buf) begin
        put_token(psl_pkg::K_ID, 0, 0, i + 1, 0, 0, trunc_flag);
        return;
      end
    end
    if (sym_count < TABLE_ENTRIES) begin
      sym_names[sym_count] = name_buf;
      sym_count++;
      put_token(psl_pkg::K_ID, 0, 0, sym_count, 0, 0, trunc_flag);
    end else begin
      put_token(psl_pkg::K_ID, 0, 0, 0, 0, 1, trunc_flag);
    end
  endfunction

  function automatic void start_from_idle(logic [7:0] c, bit eof);
    if (eof) begin
      end_token();
      return;
    end
    if (is_ws(c)) return;
    if (is_dig(c)) begin
      mode = S_INT; acc = c - "0"; frac_cnt = 0; sat_flag = 0;
      return;
    end
    if (is_let(c)) begin
      mode = S_WORD; name_buf = ""; trunc_flag = 0; add_letter(c);
      return;
    end
    case (c)
      psl_pkg::CH_PLUS:   put_token(psl_pkg::K_PLUS);
      psl_pkg::CH_MINUS:  put_token(psl_pkg::K_MINUS);
      psl_pkg::CH_STAR:   put_token(psl_pkg::K_TIMES);
      psl_pkg::CH_SLASH:  put_token(psl_pkg::K_SLASH);
      psl_pkg::CH_EQ:     put_token(psl_pkg::K_EQ);
      psl_pkg::CH_SEMI:   put_token(psl_pkg::K_SEMI);
      psl_pkg::CH_COMMA:  put_token(psl_pkg::K_COMMA);
      psl_pkg::CH_RPAREN: put_token(psl_pkg::K_RPAR);
      psl_pkg::CH_LPAREN: mode = S_PAREN;
      psl_pkg::CH_LBRACE: mode = S_COMMENT;
      psl_pkg::CH_LT:     mode = S_LT;
      psl_pkg::CH_GT:     mode = S_GT;
      psl_pkg::CH_COLON:  mode = S_COLON;
      psl_pkg::CH_DOT:    mode = S_DOT;
      default:            put_token(psl_pkg::K_INVALID);
    endcase
  endfunction

  // one scan pass; returns 1 when the character is pushed back
  function automatic bit scan_pass(logic [7:0] c, bit eof);
    scan_e m;
    int unsigned d;
    m = mode;
    d = c - "0";
    mode = S_IDLE;
    case (m)
      S_COMMENT, S_STAR: begin
        if (eof) begin
          end_token();
          return 0;
        end
        if (c == psl_pkg::CH_RBRACE || (m == S_STAR && c == psl_pkg::CH_RPAREN)) return 0;
        mode = (c == psl_pkg::CH_STAR) ? S_STAR : S_COMMENT;
        return 0;
      end
      S_PAREN: begin
        if (!eof && c == psl_pkg::CH_STAR) begin
          mode = S_COMMENT;
          return 0;
        end
        put_token(psl_pkg::K_LPAR);
        return 1;
      end
      S_LT: begin
        if (!eof && c == psl_pkg::CH_EQ) begin put_token(psl_pkg::K_LE); return 0; end
        if (!eof && c == psl_pkg::CH_GT) begin put_token(psl_pkg::K_NE); return 0; end
        put_token(psl_pkg::K_LT);
        return 1;
      end
      S_GT: begin
        if (!eof && c == psl_pkg::CH_EQ) begin put_token(psl_pkg::K_GE); return 0; end
        put_token(psl_pkg::K_GT);
        return 1;
      end
      S_COLON: begin
        if (!eof && c == psl_pkg::CH_EQ) begin put_token(psl_pkg::K_ASSIGN); return 0; end
        put_token(psl_pkg::K_COLON);
        return 1;
      end
      S_DOT: begin
        if (!eof && c == psl_pkg::CH_DOT) begin put_token(psl_pkg::K_DOTDOT); return 0; end
        put_token(psl_pkg::K_DOT);
        return 1;
      end
      S_INT: begin
        if (!eof && is_dig(c)) begin
          if (acc > (psl_pkg::VMAX - d) / 10) begin
            acc = psl_pkg::VMAX; sat_flag = 1;
          end else begin
            acc = acc * 10 + d;
          end
          mode = S_INT;
          return 0;
        end
        if (!eof && is_let(c)) begin mode = S_SKIP; return 0; end
        if (!eof && c == psl_pkg::CH_DOT) begin mode = S_FRAC; return 0; end
        if (eof || is_ws(c) || is_mark(c)) begin
          put_token(psl_pkg::K_INT, acc, 0, 0, 0, 0, 0, sat_flag);
          return 1;
        end
        // odd byte after a number is swallowed into one invalid token
        put_token(psl_pkg::K_INVALID);
        return 0;
      end
      S_FRAC: begin
        if (!eof && is_dig(c)) begin
          if (frac_cnt >= 31 || acc > (psl_pkg::VMAX - d) / 10) begin
            sat_flag = 1;
          end else begin
            acc = acc * 10 + d;
            frac_cnt++;
          end
          mode = S_FRAC;
          return 0;
        end
        if (!eof && is_let(c)) begin mode = S_SKIP; return 0; end
        put_token(psl_pkg::K_REAL, acc, frac_cnt, 0, 0, 0, 0, sat_flag);
        return 1;
      end
      S_SKIP: begin
        if (!eof && (is_let(c) || is_dig(c))) begin mode = S_SKIP; return 0; end
        put_token(psl_pkg::K_INVALID);
        return 1;
      end
      S_WORD: begin
        if (!eof && is_let(c)) begin add_letter(c); mode = S_WORD; return 0; end
        if (!eof && (is_dig(c) || c == psl_pkg::CH_UNDER)) begin
          add_letter(c); mode = S_IDENT;
          return 0;
        end
        word_token(1);
        return 1;
      end
      S_IDENT: begin
        if (!eof && (is_let(c) || is_dig(c) || c == psl_pkg::CH_UNDER)) begin
          add_letter(c); mode = S_IDENT;
          return 0;
        end
        word_token(0);
        return 1;
      end
      default: begin
        start_from_idle(c, eof);
        return 0;
      end
    endcase
  endfunction

  function automatic void predict_tokens(char_item_t it);
    logic [7:0] c;
    c = it.ch;
    if (c >= "A" && c <= "Z") c = c + 8'd32;
    step_tokens.delete();
    if (scan_pass(c, it.eof)) void'(scan_pass(c, it.eof));
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  int n_items = 0;

  function automatic void push_byte(logic [7:0] c, bit eof = 0);
    char_item_t it;
    it.ch = c;
    it.eof = eof;
    pending_chars.push_back(it);
    n_items++;
  endfunction

  // letters go in upper or lower case at random
  function automatic void push_text(string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 3) == 0) c = c - 8'd32;
      push_byte(c);
    end
  endfunction

  // end mark with a random ignored character code
  function automatic void push_end();
    push_byte(8'($urandom), 1'b1);
  endfunction

  function automatic string rand_digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
    return s;
  endfunction

  function automatic string rand_name();
    string s;
    int n;
    // small alphabet and short names make repeats likely
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 4);
    s = "";
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       s = {s, (i == 0) ? "x" : "_"};
        1:       s = {s, (i == 0) ? "y" : string'(8'("0" + $urandom_range(0, 9)))};
        default: s = {s, string'(8'("a" + $urandom_range(0, 5)))};
      endcase
    end
    return s;
  endfunction

  function automatic void push_separator();
    case ($urandom_range(0, 5))
      0:       ;  // tokens run together
      1:       push_byte(8'($urandom_range(9, 13)));
      default: push_byte(8'd32);
    endcase
  endfunction

  function automatic void push_random_token();
    string body;
    case ($urandom_range(0, 19))
      0, 1, 2:  push_text(keywords[$urandom_range(0, 22)]);
      3, 4, 5:  push_text(rand_name());
      6, 7:     push_text(rand_digits($urandom_range(1, ($urandom_range(0, 4) == 0) ? 12 : 3)));
      8, 9: begin
        body = {rand_digits($urandom_range(1, 4)), "."};
        body = {body, rand_digits(($urandom_range(0, 5) == 0) ? $urandom_range(0, 34)
                                                              : $urandom_range(0, 4))};
        push_text(body);
      end
      10, 11, 12, 13: push_text(operators[$urandom_range(0, 19)]);
      14: begin
        // comment with either opener and either closer
        body = ($urandom_range(0, 1) == 0) ? "{" : "(*";
        for (int i = $urandom_range(0, 5); i > 0; i--) begin
          body = {body, string'(8'($urandom_range(32, 126)))};
        end
        body = {body, ($urandom_range(0, 1) == 0) ? "}" : "*)"};
        push_text(body);
      end
      15: push_byte(8'($urandom));
      16: push_text({rand_digits(2), rand_name()});
      17: push_text({rand_digits(2), string'(8'($urandom_range(128, 255)))});
      default: push_text({rand_name(), ":=", rand_digits(2), ";"});
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one character transaction at a time with random gaps
  // ---------------------------------------------------------------------------
  int  send_gap = 0;
  bit  send_burst = 0;
  int  recv_wait = 0;
  bit  recv_burst = 0;
  bit  in_fire;
  bit  out_fire;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  always @(posedge clk or negedge rst_n) begin
    char_item_t it;
    logic next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        it.ch = char_code;
        it.eof = end_mark;
        predict_tokens(it);
        next_valid = 1'b0;
        if ($urandom_range(0, 99) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 11);
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_chars.size() > 0) begin
          it = pending_chars.pop_front();
          char_code <= it.ch;
          end_mark  <= it.eof;
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random stall, compare every token with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    token_t exp_tok;
    token_t got;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.kind = kind; got.value = number_value; got.frac = fraction_digits;
        got.sym = symbol_number; got.bv = bool_value; got.full = table_full;
        got.trunc = name_truncated; got.sat = number_saturated; got.last = last;
        if (expected_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected token: kind %0d", got.kind);
        end else begin
          exp_tok = expected_tokens.pop_front();
          if (got !== exp_tok) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display({"token mismatch: exp kind %0d val %0d frac %0d sym %0d bv %0d",
                        " full %0d tr %0d sat %0d last %0d"},
                       exp_tok.kind, exp_tok.value, exp_tok.frac, exp_tok.sym, exp_tok.bv,
                       exp_tok.full, exp_tok.trunc, exp_tok.sat, exp_tok.last);
              $display({"                got kind %0d val %0d frac %0d sym %0d bv %0d",
                        " full %0d tr %0d sat %0d last %0d"},
                       got.kind, got.value, got.frac, got.sym, got.bv,
                       got.full, got.trunc, got.sat, got.last);
            end
          end
        end
        if ($urandom_range(0, 79) == 0) recv_burst = !recv_burst;
        recv_wait = recv_burst ? 0 : $urandom_range(0, 11);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_stall <= (recv_wait > 0);
    end
  end

  // watchdog on cycles without any transaction
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_fire || out_fire) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("pascal_subset_lexer_top test failed");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    // directed: keyword in caps, assignment, real forms, saturated integer,
    // number then letters, odd byte after a number, both comment styles with
    // crossed closers, stray marks, a high byte, end right inside a comment
    push_text("BEGIN x:=2147483648 1..2. 3ab$");
    push_byte(8'd7); push_text("5"); push_byte(8'hff);
    push_text("{a*)(*b}_}<>>=");
    push_byte(8'h80);
    push_text("{z");
    push_end();
    // enough distinct names to fill the table, then an end mark
    for (int i = 0; i < TABLE_ENTRIES + 4; i++) begin
      push_text($sformatf("v%0d ", i % (TABLE_ENTRIES + 2)));
    end
    push_end();
    while (n_items < N_ITEMS) begin
      push_random_token();
      push_separator();
      if ($urandom_range(0, 60) == 0) push_end();
    end
    push_end();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_chars.size() == 0 && !in_valid);
    wait (expected_tokens.size() == 0);
    repeat (200) @(posedge clk);
    if (expected_tokens.size() != 0) mismatches++;

    if (mismatches == 0) begin
      $display("pascal_subset_lexer_top test passed");
    end else begin
      $display("pascal_subset_lexer_top test failed");
    end
    $finish;
  end

endmodule
